// File: rtl/core/distance_vector_route_update_assert.svh
// assertion macros for the route update block
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`ifndef SYNTH
`define DVR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DVR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DVR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DVR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// shared types and codes of the distance-vector route update block
// ----------------------------------------------------------------------------
package dvr_pkg;
  localparam logic [1:0] KIND_LINK   = 2'd0;
  localparam logic [1:0] KIND_ADVERT = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [15:0] COST_MAX = 16'hffff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sender_id;
    logic [7:0]  dest_id;
    logic [15:0] cost;
    logic        ignore;
  } req_t;

  typedef struct packed {
    logic        changed;
    logic        found;
    logic [7:0]  hop_id;
    logic [15:0] path_cost;
    logic        table_full;
  } rsp_t;
endpackage

// File: rtl/core/dvr_fifo.sv
// ----------------------------------------------------------------------------
// dvr_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
module dvr_fifo #(
  parameter int Depth = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  dvr_pkg::req_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output dvr_pkg::req_t  rd_data,
  output logic           empty
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  dvr_pkg::req_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full = (cnt_r == (AW+1)'(Depth));
  assign empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd_en && !empty) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end
endmodule

// File: rtl/core/dvr_front.sv
// ----------------------------------------------------------------------------
// dvr_front
// accepts requests, classifies own-id and unused kinds as ignored
// ----------------------------------------------------------------------------
module dvr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_sender_id,
  input  logic [7:0]    in_dest_id,
  input  logic [15:0]   in_cost,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_own_id,
  output logic          q_wr,
  output dvr_pkg::req_t q_data,
  input  logic          q_full
);
  logic [7:0] own_id_r;

  assign cfg_ready = 1'b1;
  assign in_full = q_full;
  assign q_wr = in_push;

  always_comb begin
    q_data.kind = in_kind;
    q_data.sender_id = in_sender_id;
    q_data.dest_id = in_dest_id;
    q_data.cost = in_cost;
    q_data.ignore = (in_kind == dvr_pkg::KIND_UNUSED) ||
                    ((in_kind != dvr_pkg::KIND_LOOKUP) && (in_dest_id == own_id_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) own_id_r <= '0;
    else if (cfg_valid) own_id_r <= cfg_own_id;
  end
endmodule

// File: rtl/core/dvr_back.sv
// ----------------------------------------------------------------------------
// dvr_back
// sequential search of neighbor and route tables, update and result register
// ----------------------------------------------------------------------------
`include "distance_vector_route_update_assert.svh"
module dvr_back #(
  parameter int TableDepth = 32,
  parameter int NeighborDepth = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  dvr_pkg::req_t q_data,
  output logic          q_rd,
  output logic          out_empty,
  input  logic          out_pop,
  output logic          out_changed,
  output logic          out_found,
  output logic [7:0]    out_hop_id,
  output logic [15:0]   out_path_cost,
  output logic          out_table_full
);
  localparam int TW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int NW = (NeighborDepth > 1) ? $clog2(NeighborDepth) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LINK  = 6'b000010,
    S_ROUTE = 6'b000100,
    S_APPLY = 6'b001000,
    S_OUT   = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  dvr_pkg::req_t req_r;
  logic [7:0]  link_id_r [NeighborDepth];
  logic [15:0] link_cost_r [NeighborDepth];
  logic [7:0]  rdest_r [TableDepth];
  logic [15:0] rcost_r [TableDepth];
  logic [7:0]  rhop_r [TableDepth];
  logic [NW:0] link_count_r, li_r;
  logic [TW:0] route_count_r, ri_r;
  logic        lhit_r, rhit_r;
  logic [NW-1:0] lidx_r;
  logic [TW-1:0] ridx_r;
  logic [15:0] lcost_r;
  dvr_pkg::rsp_t rsp_r;
  logic [16:0] sum;
  logic [15:0] ocost;
  logic [7:0]  ohop, rkey;

  assign q_rd = (state_r == S_IDLE) && !q_empty;
  assign out_empty = (state_r != S_HOLD);
  assign out_changed = rsp_r.changed;
  assign out_found = rsp_r.found;
  assign out_hop_id = rsp_r.hop_id;
  assign out_path_cost = rsp_r.path_cost;
  assign out_table_full = rsp_r.table_full;

  assign sum = {1'b0, req_r.cost} + {1'b0, (lhit_r ? lcost_r : 16'd0)};
  assign ocost = (req_r.kind == dvr_pkg::KIND_LINK) ? req_r.cost :
                 (sum[16] ? dvr_pkg::COST_MAX : sum[15:0]);
  assign ohop = (req_r.kind == dvr_pkg::KIND_LINK) ? req_r.dest_id : req_r.sender_id;
  assign rkey = (req_r.kind == dvr_pkg::KIND_ADVERT) ? req_r.sender_id : req_r.dest_id;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_LINK;
      S_LINK: if (req_r.ignore) state_nxt = S_OUT;
        else if (req_r.kind == dvr_pkg::KIND_LOOKUP || li_r >= link_count_r ||
                 lhit_r) state_nxt = S_ROUTE;
      S_ROUTE: if (ri_r >= route_count_r || rhit_r) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_OUT;
      S_OUT: state_nxt = S_HOLD;
      S_HOLD: if (out_pop) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      link_count_r <= '0;
      route_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_APPLY && !req_r.ignore) begin
        if (req_r.kind == dvr_pkg::KIND_LINK && !lhit_r &&
            link_count_r < (NW+1)'(NeighborDepth))
          link_count_r <= link_count_r + 1'b1;
        if (req_r.kind != dvr_pkg::KIND_LOOKUP && !rhit_r &&
            route_count_r < (TW+1)'(TableDepth))
          route_count_r <= route_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r <= q_data;
        li_r <= '0;
        ri_r <= '0;
        lhit_r <= 1'b0;
        rhit_r <= 1'b0;
        rsp_r <= '0;
      end
      S_LINK: if (!lhit_r && li_r < link_count_r) begin
        if (link_id_r[li_r[NW-1:0]] == rkey) begin
          lhit_r <= 1'b1;
          lidx_r <= li_r[NW-1:0];
          lcost_r <= link_cost_r[li_r[NW-1:0]];
        end else li_r <= li_r + 1'b1;
      end
      S_ROUTE: if (!rhit_r && ri_r < route_count_r) begin
        if (rdest_r[ri_r[TW-1:0]] == req_r.dest_id) begin
          rhit_r <= 1'b1;
          ridx_r <= ri_r[TW-1:0];
        end else ri_r <= ri_r + 1'b1;
      end
      S_APPLY: if (!req_r.ignore) begin
        if (req_r.kind == dvr_pkg::KIND_LOOKUP) begin
          if (rhit_r) begin
            rsp_r.found <= 1'b1;
            rsp_r.hop_id <= rhop_r[ridx_r];
            rsp_r.path_cost <= rcost_r[ridx_r];
          end
        end else begin
          if (req_r.kind == dvr_pkg::KIND_LINK) begin
            if (lhit_r) link_cost_r[lidx_r] <= req_r.cost;
            else if (link_count_r < (NW+1)'(NeighborDepth)) begin
              link_id_r[link_count_r[NW-1:0]] <= req_r.dest_id;
              link_cost_r[link_count_r[NW-1:0]] <= req_r.cost;
            end
          end
          if (rhit_r) begin
            if (ocost < rcost_r[ridx_r]) begin
              rcost_r[ridx_r] <= ocost;
              rhop_r[ridx_r] <= ohop;
              rsp_r.changed <= 1'b1;
              rsp_r.hop_id <= ohop;
              rsp_r.path_cost <= ocost;
            end
          end else if (route_count_r < (TW+1)'(TableDepth)) begin
            rdest_r[route_count_r[TW-1:0]] <= req_r.dest_id;
            rcost_r[route_count_r[TW-1:0]] <= ocost;
            rhop_r[route_count_r[TW-1:0]] <= ohop;
            rsp_r.changed <= 1'b1;
            rsp_r.hop_id <= ohop;
            rsp_r.path_cost <= ocost;
          end else rsp_r.table_full <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  `DVR_ASSERT_IMP(a_rc_bound, clk, rst_n, 1'b1, route_count_r <= (TW+1)'(TableDepth))
  `DVR_ASSERT_IMP(a_lc_bound, clk, rst_n, 1'b1, link_count_r <= (NW+1)'(NeighborDepth))
  `DVR_ASSERT_IMP(a_rsp_excl, clk, rst_n, state_r == S_HOLD,
    !(rsp_r.changed && rsp_r.table_full) && !(rsp_r.found && rsp_r.changed))
  `DVR_ASSERT_NXT(a_hold_stay, clk, rst_n, state_r == S_HOLD && !out_pop, state_r == S_HOLD)
endmodule

// File: rtl/core/distance_vector_route_update.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update
// distance-vector route table with link, advertisement and lookup requests
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in_      in         push / full
// out_     out        empty / pop
// cfg_     in         valid / ready (ready always high)
// a request passes the link search, route search, apply, out and hold states
// an ignored request goes from the link state straight to out
// the back end scans neighbor then route entries one per cycle
// reset clears counts and own id; table contents need no clearing
// a result held unpopped stalls the back end; the queue then fills
module distance_vector_route_update #(
  parameter int TABLE_DEPTH = 32,
  parameter int NEIGHBOR_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_sender_id,
  input  logic [7:0]  in_dest_id,
  input  logic [15:0] in_cost,
  output logic        empty,
  input  logic        pop,
  output logic        out_changed,
  output logic        out_found,
  output logic [7:0]  out_hop_id,
  output logic [15:0] out_path_cost,
  output logic        out_table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_own_id
);
  logic q_wr, q_full, q_rd, q_empty;
  dvr_pkg::req_t q_wdata, q_rdata;

  dvr_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_kind, .in_sender_id,
    .in_dest_id, .in_cost, .cfg_valid, .cfg_ready, .cfg_own_id,
    .q_wr, .q_data(q_wdata), .q_full
  );

  dvr_fifo #(.Depth(2)) u_fifo (
    .clk, .rst_n, .wr_en(q_wr), .wr_data(q_wdata), .full(q_full),
    .rd_en(q_rd), .rd_data(q_rdata), .empty(q_empty)
  );

  dvr_back #(.TableDepth(TABLE_DEPTH), .NeighborDepth(NEIGHBOR_DEPTH)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_rdata), .q_rd, .out_empty(empty),
    .out_pop(pop), .out_changed, .out_found, .out_hop_id, .out_path_cost,
    .out_table_full
  );
endmodule
